// File: rtl/core/pkcs1_chk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs1_chk_pkg
// Shared constants, types and the DigestInfo prefix table for the
// PKCS#1 v1.5 encoded message checker.
// ----------------------------------------------------------------------------
package pkcs1_chk_pkg;

   // Message layout
   localparam int DIGEST_OCTETS  = 32;
   localparam int PREFIX_OCTETS  = 19;
   localparam int MIN_PAD_OCTETS = 8;

   localparam int POS_W    = 9;
   localparam int PREFIX_W = 5;
   localparam int DIDX_W   = 5;
   localparam int DCNT_W   = 6;
   localparam int PAD_W    = $clog2(MIN_PAD_OCTETS + 1);

   // Message lengths selected by the key length register
   localparam logic [POS_W-1:0] MSG_LEN_2048 = POS_W'(256);
   localparam logic [POS_W-1:0] MSG_LEN_3072 = POS_W'(384);

   // Fixed octet values
   localparam logic [7:0] OCT_ZERO = 8'h00;
   localparam logic [7:0] OCT_ONE  = 8'h01;
   localparam logic [7:0] OCT_PAD  = 8'hFF;

   // Key length register codes
   localparam logic KEY_MODE_2048 = 1'b0;
   localparam logic KEY_MODE_3072 = 1'b1;

   // Result of one parse step
   typedef struct packed {
      logic                have_result;
      logic [7:0]          digest_byte;
      logic [DIDX_W-1:0]   digest_index;
      logic                is_digest;
      logic                done_res;
      logic                valid_res;
   } parse_res_type;

   // SHA-256 DigestInfo prefix
   function automatic logic [7:0] sha256_prefix(input logic [PREFIX_W-1:0] idx);
      logic [7:0] val;
      val = 8'h00;
      case (idx)
         5'd0:  val = 8'h30;
         5'd1:  val = 8'h31;
         5'd2:  val = 8'h30;
         5'd3:  val = 8'h0d;
         5'd4:  val = 8'h06;
         5'd5:  val = 8'h09;
         5'd6:  val = 8'h60;
         5'd7:  val = 8'h86;
         5'd8:  val = 8'h48;
         5'd9:  val = 8'h01;
         5'd10: val = 8'h65;
         5'd11: val = 8'h03;
         5'd12: val = 8'h04;
         5'd13: val = 8'h02;
         5'd14: val = 8'h01;
         5'd15: val = 8'h05;
         5'd16: val = 8'h00;
         5'd17: val = 8'h04;
         5'd18: val = 8'h20;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/core/pkcs1_chk_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs1_chk_parse
// Phase machine that walks the encoded message one octet per step and
// computes the result for that octet; parse state updates on step.
// ----------------------------------------------------------------------------
module pkcs1_chk_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [7:0]                   octet,
   input  logic                         start_req,
   input  logic                         key_mode,
   output pkcs1_chk_pkg::parse_res_type res
);
   import pkcs1_chk_pkg::*;

   typedef enum logic [2:0] {
      PH_ZERO   = 3'd0,
      PH_ONE    = 3'd1,
      PH_PAD    = 3'd2,
      PH_PREFIX = 3'd3,
      PH_DIGEST = 3'd4,
      PH_END    = 3'd5,
      PH_DROP   = 3'd6
   } phase_type;

   phase_type             phase_ff, phase_in, phase_cur;
   logic [POS_W-1:0]      pos_ff, pos_in, pos_cur;
   logic [PAD_W-1:0]      pad_ff, pad_in, pad_cur;
   logic [PREFIX_W-1:0]   pfx_ff, pfx_in, pfx_cur;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in, dcnt_cur;
   logic                  failed_ff, failed_in, failed_cur;

   logic [POS_W-1:0]      msg_len;
   logic                  last;
   logic                  bad;
   logic                  emit;
   logic [DIDX_W-1:0]     didx;
   logic [PREFIX_W-1:0]   pfx_next;
   logic [DCNT_W-1:0]     dcnt_next;

   // Start of a new message clears the parse state before use
   always_comb begin
      if (start_req) begin
         phase_cur  = PH_ZERO;
         pos_cur    = '0;
         pad_cur    = '0;
         pfx_cur    = '0;
         dcnt_cur   = '0;
         failed_cur = 1'b0;
      end else begin
         phase_cur  = phase_ff;
         pos_cur    = pos_ff;
         pad_cur    = pad_ff;
         pfx_cur    = pfx_ff;
         dcnt_cur   = dcnt_ff;
         failed_cur = failed_ff;
      end
   end

   assign msg_len   = (key_mode == KEY_MODE_3072) ? MSG_LEN_3072 : MSG_LEN_2048;
   assign last      = (pos_cur == msg_len - POS_W'(1));
   assign pfx_next  = pfx_cur + PREFIX_W'(1);
   assign dcnt_next = dcnt_cur + DCNT_W'(1);

   // Phase decode for one octet
   always_comb begin
      phase_in = phase_cur;
      pad_in   = pad_cur;
      pfx_in   = pfx_cur;
      dcnt_in  = dcnt_cur;
      bad      = 1'b0;
      emit     = 1'b0;
      didx     = '0;
      unique case (phase_cur)
         PH_ZERO: begin
            if (octet != OCT_ZERO) bad = 1'b1;
            else                   phase_in = PH_ONE;
         end
         PH_ONE: begin
            if (octet != OCT_ONE) bad = 1'b1;
            else                  phase_in = PH_PAD;
         end
         PH_PAD: begin
            if (octet == OCT_PAD) begin
               // run length saturates once the minimum is reached
               if (pad_cur < PAD_W'(MIN_PAD_OCTETS)) pad_in = pad_cur + PAD_W'(1);
            end else if (octet == OCT_ZERO && pad_cur >= PAD_W'(MIN_PAD_OCTETS)) begin
               phase_in = PH_PREFIX;
               pfx_in   = '0;
            end else begin
               bad = 1'b1;
            end
         end
         PH_PREFIX: begin
            if (pfx_cur >= PREFIX_W'(PREFIX_OCTETS) || octet != sha256_prefix(pfx_cur)) begin
               bad = 1'b1;
            end else begin
               pfx_in = pfx_next;
               if (pfx_next == PREFIX_W'(PREFIX_OCTETS)) begin
                  // digest must end exactly at the message end
                  if ({1'b0, pos_cur} + 10'd1 !=
                      {1'b0, msg_len} - 10'(DIGEST_OCTETS)) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_DIGEST;
                     dcnt_in  = '0;
                  end
               end
            end
         end
         PH_DIGEST: begin
            emit    = 1'b1;
            didx    = dcnt_cur[DIDX_W-1:0];
            dcnt_in = dcnt_next;
            if (dcnt_next >= DCNT_W'(DIGEST_OCTETS)) phase_in = PH_END;
         end
         PH_END: begin
            bad = 1'b1;
         end
         default: begin
         end
      endcase
      if (bad) phase_in = PH_DROP;
   end

   assign failed_in = failed_cur | bad;
   assign pos_in    = pos_cur + POS_W'(1);

   // Result for this octet
   always_comb begin
      res.have_result  = emit | last;
      res.digest_byte  = emit ? octet : 8'h00;
      res.digest_index = didx;
      res.is_digest    = emit;
      res.done_res     = last;
      res.valid_res    = last & ~failed_in & (phase_in == PH_END);
   end

   // Parse state; returns to reset after the final octet
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ZERO;
         pos_ff    <= '0;
         pad_ff    <= '0;
         pfx_ff    <= '0;
         dcnt_ff   <= '0;
         failed_ff <= 1'b0;
      end else if (step) begin
         if (last) begin
            phase_ff  <= PH_ZERO;
            pos_ff    <= '0;
            pad_ff    <= '0;
            pfx_ff    <= '0;
            dcnt_ff   <= '0;
            failed_ff <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            pad_ff    <= pad_in;
            pfx_ff    <= pfx_in;
            dcnt_ff   <= dcnt_in;
            failed_ff <= failed_in;
         end
      end
   end

endmodule

// File: rtl/core/pkcs1_v15_encoded_message_checker.sv
`timescale 1ns / 1ps
// Flow: an item is registered on accept, parsed from the input register and its
//   result (if any) is presented from the output register.
// Throughput: one item per cycle; the input register and the output register
//   advance together whenever the output register is empty or being taken.
// Reset: synchronous, active high; clears the parse state, the key length
//   register (2048-bit mode) and both stage valid flags.
// ----------------------------------------------------------------------------
// pkcs1_v15_encoded_message_checker
// Checks an EMSA-PKCS1-v1_5 encoded message with a SHA-256 DigestInfo,
// streams out the digest octets and a final done item with the verdict.
// ----------------------------------------------------------------------------
module pkcs1_v15_encoded_message_checker (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic        csr_wdata,     // key_length_mode
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] octet
   input  logic        req_tuser,     // [0] start_req
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [7:0] digest_byte, [12:8] digest_index, zero fill
   output logic        rsp_tlast,     // done_res
   output logic [1:0]  rsp_tuser      // [0] is_digest, [1] valid_res
);
   import pkcs1_chk_pkg::*;

   logic          key_mode_ff;
   logic          in_valid_ff;
   logic [7:0]    in_octet_ff;
   logic          in_start_ff;
   logic          advance;
   parse_res_type res;
   logic          out_valid_ff;
   parse_res_type out_ff;

   // Key length register
   always_ff @(posedge clock) begin
      if (reset) key_mode_ff <= KEY_MODE_2048;
      else if (csr_we) key_mode_ff <= csr_wdata;
   end

   // The stage moves when the output register can take a new item
   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = ~in_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_octet_ff <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   pkcs1_chk_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (in_valid_ff & advance),
      .octet     (in_octet_ff),
      .start_req (in_start_ff),
      .key_mode  (key_mode_ff),
      .res       (res)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff & res.have_result;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) out_ff <= res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.digest_index, out_ff.digest_byte};
   assign rsp_tlast  = out_ff.done_res;
   assign rsp_tuser  = {out_ff.valid_res, out_ff.is_digest};

   // have_result only gates the valid flag
   logic unused_have;
   assign unused_have = out_ff.have_result;

endmodule
